[rtl/hls_pkg.sv]
// ----------------------------------------------------------------------------
// hls_pkg
// Types and constants shared by the heartbeat link supervisor files.
// ----------------------------------------------------------------------------
`default_nettype none

package hls_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 8;
    localparam int CMD_W      = 16;

    localparam logic [BYTE_W-1:0] SUM_OK = 8'hFF;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_WAIT_RESP = 5'b00010,
        PH_WAIT_CONF = 5'b00100,
        PH_HB_WAIT   = 5'b01000,
        PH_HB_RECV   = 5'b10000
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEARTBEAT_CODE = 3'd0,
        CFG_INIT_CODE      = 3'd1,
        CFG_RESPONSE_CODE  = 3'd2,
        CFG_CONFIRM_CODE   = 3'd3,
        CFG_DEVICE_ID      = 3'd4,
        CFG_FRAME_TIMEOUT  = 3'd5,
        CFG_LINK_TIMEOUT   = 3'd6,
        CFG_CONNECT_WAIT   = 3'd7
    } t_cfg_idx;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

endpackage

`default_nettype wire

[rtl/hls_if.sv]
// ----------------------------------------------------------------------------
// hls_if
// Valid/ready channels of the heartbeat link supervisor: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface hls_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface hls_rsp_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        send_reply;
    logic        command_valid;
    logic [15:0] command_value;
    logic        connected_now;

    modport source (
        output valid, output tx_valid, output tx_byte, output send_reply,
        output command_valid, output command_value, output connected_now,
        input ready
    );
    modport sink (
        input valid, input tx_valid, input tx_byte, input send_reply,
        input command_valid, input command_value, input connected_now,
        output ready
    );
endinterface

`default_nettype wire

[rtl/heartbeat_link_supervisor_top.sv]
// ----------------------------------------------------------------------------
// heartbeat_link_supervisor_top
// Node-side serial link supervisor: connect handshake, heartbeat frames,
// frame and link timeouts.
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    action, rx_byte
//   o_rsp     out   valid / ready    tx_valid, tx_byte, send_reply,
//                                    command_valid, command_value, connected_now
//   i_cfg_*   in    write enable     register index, write data
//
// One request per cycle; its result shows in the output register in the cycle
// after acceptance. State updates in the accepting cycle, so the next request
// may follow at once. i_req.ready drops only while a result waits unread.
// Synchronous active-low reset clears link state, timers and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_link_supervisor_top
    import hls_pkg::*;
#(
    parameter int FRAME_BYTES = 16,
    parameter int TIMER_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hls_req_if.sink                    i_req,
    hls_rsp_if.source                  o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int FC_W  = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    logic [CODE_W-1:0]     r_hb_code, r_init_code, r_resp_code, r_conf_code, r_dev_id;
    logic [CFG_DATA_W-1:0] r_frame_to, r_link_to, r_conn_wait;

    logic                  r_link, n_link;
    t_phase                r_phase, n_phase;
    logic [FC_W-1:0]       r_fc, n_fc;
    logic [BYTE_W-1:0]     r_sum, n_sum;
    logic [BYTE_W-1:0]     r_cmd_lo, n_cmd_lo, r_cmd_hi, n_cmd_hi;
    logic [TIMER_BITS-1:0] r_frame_t, n_frame_t, r_sil_t, n_sil_t, r_wait_t, n_wait_t;
    logic [BYTE_W-1:0]     r_win_byte, n_win_byte;
    logic                  r_win_seen, n_win_seen;

    logic                  r_out_valid;
    logic                  r_tx_valid, n_tx_valid;
    logic [BYTE_W-1:0]     r_tx_byte, n_tx_byte;
    logic                  r_reply, n_reply;
    logic                  r_cmd_valid, n_cmd_valid;
    logic [CMD_W-1:0]      r_cmd_value, n_cmd_value;

    logic                  accept;
    logic                  is_byte;
    logic [BYTE_W-1:0]     b;
    logic [FC_W-1:0]       fc_inc;
    logic [BYTE_W-1:0]     sum_inc;
    logic [TIMER_BITS-1:0] wait_inc, frame_inc, sil_inc;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_byte     = (i_req.action == ACT_BYTE);
    assign b           = i_req.rx_byte;
    assign fc_inc      = r_fc + 1'b1;
    assign sum_inc     = r_sum + b;
    assign wait_inc    = (r_wait_t == TMAX) ? r_wait_t : r_wait_t + 1'b1;
    assign frame_inc   = (r_frame_t == TMAX) ? r_frame_t : r_frame_t + 1'b1;
    assign sil_inc     = (r_sil_t == TMAX) ? r_sil_t : r_sil_t + 1'b1;

    always_comb begin
        n_link      = r_link;
        n_phase     = r_phase;
        n_fc        = r_fc;
        n_sum       = r_sum;
        n_cmd_lo    = r_cmd_lo;
        n_cmd_hi    = r_cmd_hi;
        n_frame_t   = r_frame_t;
        n_sil_t     = r_sil_t;
        n_wait_t    = r_wait_t;
        n_win_byte  = r_win_byte;
        n_win_seen  = r_win_seen;
        n_tx_valid  = 1'b0;
        n_tx_byte   = '0;
        n_reply     = 1'b0;
        n_cmd_valid = 1'b0;
        n_cmd_value = '0;

        if (!r_link) begin
            if (r_phase != PH_WAIT_RESP && r_phase != PH_WAIT_CONF) begin
                n_tx_valid = 1'b1;
                n_tx_byte  = r_init_code;
                n_phase    = PH_WAIT_RESP;
                n_wait_t   = '0;
                n_win_seen = is_byte;
                n_win_byte = is_byte ? b : '0;
            end else if (is_byte) begin
                if (!r_win_seen) begin
                    n_win_byte = b;
                    n_win_seen = 1'b1;
                end
            end else begin
                n_wait_t = wait_inc;
                if (CMP_W'(wait_inc) >= CMP_W'(r_conn_wait)) begin
                    if (r_phase == PH_WAIT_RESP && r_win_seen && r_win_byte == r_resp_code) begin
                        n_tx_valid = 1'b1;
                        n_tx_byte  = r_dev_id;
                        n_phase    = PH_WAIT_CONF;
                        n_wait_t   = '0;
                        n_win_seen = 1'b0;
                        n_win_byte = '0;
                    end else if (r_phase == PH_WAIT_CONF && r_win_seen
                                 && r_win_byte == r_conf_code) begin
                        n_link     = 1'b1;
                        n_phase    = PH_HB_WAIT;
                        n_sil_t    = '0;
                        n_fc       = '0;
                        n_wait_t   = '0;
                        n_win_seen = 1'b0;
                    end else begin
                        n_tx_valid = 1'b1;
                        n_tx_byte  = r_init_code;
                        n_phase    = PH_WAIT_RESP;
                        n_wait_t   = '0;
                        n_win_seen = 1'b0;
                        n_win_byte = '0;
                    end
                end
            end
        end else if (is_byte) begin
            if (r_phase == PH_HB_RECV) begin
                n_sum = sum_inc;
                if (r_fc == FC_W'(1)) n_cmd_lo = b;
                if (r_fc == FC_W'(2)) n_cmd_hi = b;
                n_fc = fc_inc;
                if (fc_inc >= FC_W'(FRAME_BYTES)) begin
                    n_reply = 1'b1;
                    if (sum_inc == SUM_OK) begin
                        n_cmd_valid = 1'b1;
                        n_cmd_value = {n_cmd_hi, n_cmd_lo};
                    end
                    n_phase = PH_HB_WAIT;
                    n_fc    = '0;
                end
            end else if (b == r_hb_code) begin
                n_sil_t   = '0;
                n_sum     = b;
                n_fc      = FC_W'(1);
                n_frame_t = '0;
                n_phase   = PH_HB_RECV;
            end
        end else begin
            if (r_phase == PH_HB_RECV) begin
                n_frame_t = frame_inc;
                if (CMP_W'(frame_inc) > CMP_W'(r_frame_to)) begin
                    n_phase = PH_HB_WAIT;
                    n_fc    = '0;
                end
            end
            n_sil_t = sil_inc;
            if (CMP_W'(sil_inc) > CMP_W'(r_link_to)) begin
                n_link  = 1'b0;
                n_phase = PH_IDLE;
                n_fc    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_code   <= '0;
            r_init_code <= '0;
            r_resp_code <= '0;
            r_conf_code <= '0;
            r_dev_id    <= '0;
            r_frame_to  <= CFG_DATA_W'(10);
            r_link_to   <= CFG_DATA_W'(1000);
            r_conn_wait <= CFG_DATA_W'(100);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HEARTBEAT_CODE: r_hb_code   <= i_cfg_wdata[CODE_W-1:0];
                CFG_INIT_CODE:      r_init_code <= i_cfg_wdata[CODE_W-1:0];
                CFG_RESPONSE_CODE:  r_resp_code <= i_cfg_wdata[CODE_W-1:0];
                CFG_CONFIRM_CODE:   r_conf_code <= i_cfg_wdata[CODE_W-1:0];
                CFG_DEVICE_ID:      r_dev_id    <= i_cfg_wdata[CODE_W-1:0];
                CFG_FRAME_TIMEOUT:  r_frame_to  <= i_cfg_wdata;
                CFG_LINK_TIMEOUT:   r_link_to   <= i_cfg_wdata;
                CFG_CONNECT_WAIT:   r_conn_wait <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link     <= 1'b0;
            r_phase    <= PH_IDLE;
            r_fc       <= '0;
            r_sum      <= '0;
            r_cmd_lo   <= '0;
            r_cmd_hi   <= '0;
            r_frame_t  <= '0;
            r_sil_t    <= '0;
            r_wait_t   <= '0;
            r_win_byte <= '0;
            r_win_seen <= 1'b0;
        end else if (accept) begin
            r_link     <= n_link;
            r_phase    <= n_phase;
            r_fc       <= n_fc;
            r_sum      <= n_sum;
            r_cmd_lo   <= n_cmd_lo;
            r_cmd_hi   <= n_cmd_hi;
            r_frame_t  <= n_frame_t;
            r_sil_t    <= n_sil_t;
            r_wait_t   <= n_wait_t;
            r_win_byte <= n_win_byte;
            r_win_seen <= n_win_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx_valid  <= n_tx_valid;
            r_tx_byte   <= n_tx_byte;
            r_reply     <= n_reply;
            r_cmd_valid <= n_cmd_valid;
            r_cmd_value <= n_cmd_value;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.tx_valid      = r_tx_valid;
    assign o_rsp.tx_byte       = r_tx_byte;
    assign o_rsp.send_reply    = r_reply;
    assign o_rsp.command_valid = r_cmd_valid;
    assign o_rsp.command_value = r_cmd_value;
    assign o_rsp.connected_now = r_link;

    a_cmd_needs_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_cmd_valid) |-> r_reply)
        else $error("command without frame completion");

    a_link_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link |-> (r_phase == PH_HB_WAIT || r_phase == PH_HB_RECV))
        else $error("link up outside heartbeat phases");

    a_tx_link_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tx_valid) |-> !r_link)
        else $error("handshake byte sent while link up");

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc < FC_W'(FRAME_BYTES))
        else $error("frame count out of range");

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for heartbeat_link_supervisor_top. A queue of ticks and received
// bytes feeds the request channel; a request-level predictor of the link
// supervisor tracks handshake, heartbeat frames and timeouts and checks every
// result field by field. Both channels idle and stall at random, and the
// registers are reprogrammed between traffic phases.
// ----------------------------------------------------------------------------
module tb_top;
    import hls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int FRAME_BYTES  = 16;
    localparam int N_PHASES     = 8;
    localparam int RANDOM_ITEMS = 1424;
    localparam int LONG_STALL   = 60;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_link_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        send_reply;
        logic        command_valid;
        logic [15:0] command_value;
        logic        connected_now;
    } t_link_status;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    hls_req_if req_if ();
    hls_rsp_if rsp_if ();

    heartbeat_link_supervisor_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_link_item   queued_items[$];
    t_link_status expected_status[$];

    logic [CFG_DATA_W-1:0] link_regs [8];
    logic [CFG_DATA_W-1:0] next_regs [8];

    logic        lnk_up;
    t_phase      lnk_phase;
    int          frm_cnt;
    logic [7:0]  frm_sum;
    logic [7:0]  cmd_lo;
    logic [7:0]  cmd_hi;
    logic [15:0] frm_tmr;
    logic [15:0] quiet_tmr;
    logic [15:0] win_tmr;
    logic [7:0]  win_byte;
    logic        win_seen;

    int  items_queued  = 0;
    int  items_taken   = 0;
    int  link_ups      = 0;
    int  replies       = 0;
    int  commands      = 0;
    int  settings_used = 0;
    int  mismatch_cnt  = 0;
    int  cycle_cnt     = 0;
    bit  req_taken     = 1'b0;
    bit  quiet         = 1'b0;
    int  stall_asks    = 0;
    int  stall_served  = 0;
    int  req_gap       = 0;
    int  rsp_stall     = 0;

    function automatic logic [15:0] sat_inc(logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    function automatic void open_window(t_phase ph);
        lnk_phase = ph;
        win_tmr   = '0;
        win_seen  = 1'b0;
        win_byte  = '0;
    endfunction

    function automatic t_link_status step_link(t_link_item r);
        t_link_status res;
        res = '0;
        if (!lnk_up) begin
            if (lnk_phase != PH_WAIT_RESP && lnk_phase != PH_WAIT_CONF) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = link_regs[CFG_INIT_CODE][7:0];
                open_window(PH_WAIT_RESP);
                if (r.action == ACT_BYTE) begin
                    win_byte = r.rx_byte;
                    win_seen = 1'b1;
                end
            end else if (r.action == ACT_BYTE) begin
                if (!win_seen) begin
                    win_byte = r.rx_byte;
                    win_seen = 1'b1;
                end
            end else begin
                win_tmr = sat_inc(win_tmr);
                if (win_tmr >= link_regs[CFG_CONNECT_WAIT]) begin
                    if (lnk_phase == PH_WAIT_RESP && win_seen
                            && win_byte == link_regs[CFG_RESPONSE_CODE][7:0]) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = link_regs[CFG_DEVICE_ID][7:0];
                        open_window(PH_WAIT_CONF);
                    end else if (lnk_phase == PH_WAIT_CONF && win_seen
                            && win_byte == link_regs[CFG_CONFIRM_CODE][7:0]) begin
                        lnk_up    = 1'b1;
                        lnk_phase = PH_HB_WAIT;
                        quiet_tmr = '0;
                        frm_cnt   = 0;
                        win_tmr   = '0;
                        win_seen  = 1'b0;
                        link_ups++;
                    end else begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = link_regs[CFG_INIT_CODE][7:0];
                        open_window(PH_WAIT_RESP);
                    end
                end
            end
        end else if (r.action == ACT_BYTE) begin
            if (lnk_phase == PH_HB_RECV) begin
                frm_sum = frm_sum + r.rx_byte;
                if (frm_cnt == 1) cmd_lo = r.rx_byte;
                if (frm_cnt == 2) cmd_hi = r.rx_byte;
                frm_cnt++;
                if (frm_cnt >= FRAME_BYTES) begin
                    res.send_reply = 1'b1;
                    replies++;
                    if (frm_sum == SUM_OK) begin
                        res.command_valid = 1'b1;
                        res.command_value = {cmd_hi, cmd_lo};
                        commands++;
                    end
                    lnk_phase = PH_HB_WAIT;
                    frm_cnt   = 0;
                end
            end else if (r.rx_byte == link_regs[CFG_HEARTBEAT_CODE][7:0]) begin
                quiet_tmr = '0;
                frm_sum   = r.rx_byte;
                frm_cnt   = 1;
                frm_tmr   = '0;
                lnk_phase = PH_HB_RECV;
            end
        end else begin
            if (lnk_phase == PH_HB_RECV) begin
                frm_tmr = sat_inc(frm_tmr);
                if (frm_tmr > link_regs[CFG_FRAME_TIMEOUT]) begin
                    lnk_phase = PH_HB_WAIT;
                    frm_cnt   = 0;
                end
            end
            quiet_tmr = sat_inc(quiet_tmr);
            if (quiet_tmr > link_regs[CFG_LINK_TIMEOUT]) begin
                lnk_up    = 1'b0;
                lnk_phase = PH_IDLE;
                frm_cnt   = 0;
            end
        end
        res.connected_now = lnk_up;
        return res;
    endfunction

    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatch_cnt++;
        end
    endfunction

    // Sample both channels and the register port at the rising edge.
    always @(posedge i_clk) begin
        t_link_status want;
        cycle_cnt++;
        if (i_rst_n) begin
            if (i_cfg_we) link_regs[i_cfg_idx] = i_cfg_wdata;
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_status.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("tx_valid", want.tx_valid, rsp_if.tx_valid);
                    check_field("tx_byte", want.tx_byte, rsp_if.tx_byte);
                    check_field("send_reply", want.send_reply, rsp_if.send_reply);
                    check_field("command_valid", want.command_valid, rsp_if.command_valid);
                    check_field("command_value", want.command_value, rsp_if.command_value);
                    check_field("connected_now", want.connected_now, rsp_if.connected_now);
                end
            end
        end
        req_taken = i_rst_n && req_if.valid && req_if.ready;
        if (req_taken) begin
            expected_status.push_back(step_link('{action: req_if.action,
                                                  rx_byte: req_if.rx_byte}));
            items_taken++;
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("heartbeat_link_supervisor_top: mismatch");
            $finish;
        end
    end

    // Request driver: hold until taken, then advance or idle a burst.
    always @(negedge i_clk) begin
        t_link_item nxt;
        if (req_if.valid && !req_taken) begin
        end else if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            req_gap = $urandom_range(0, 4);
        end else if (queued_items.size() > 0) begin
            nxt = queued_items.pop_front();
            req_if.valid   <= 1'b1;
            req_if.action  <= nxt.action;
            req_if.rx_byte <= nxt.rx_byte;
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Result receiver: random stall bursts plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (stall_asks != stall_served) begin
            stall_served++;
            rsp_stall = LONG_STALL;
        end
        if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall = $urandom_range(0, 4);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic push_req(logic act, logic [7:0] b);
        queued_items.push_back('{action: act, rx_byte: b});
        items_queued++;
    endtask

    task automatic push_ticks(int want, int cap);
        int n;
        n = (want > cap) ? $urandom_range(1, cap) : want;
        if (n < 1) n = 1;
        repeat (n) push_req(ACT_TICK, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_code(t_cfg_idx idx);
        return ($urandom_range(0, 99) < 85) ? link_regs[idx][7:0] : 8'($urandom);
    endfunction

    task automatic program_regs();
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= CFG_IDX_W'(i);
            i_cfg_wdata <= next_regs[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic wait_idle();
        while (queued_items.size() != 0 || items_taken != items_queued
               || expected_status.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic gen_traffic(int n_items);
        int         stop_at;
        int         kind;
        int         cut;
        logic [7:0] hb;
        logic [7:0] sum;
        logic [7:0] fb;
        stop_at = items_queued + n_items;
        hb = link_regs[CFG_HEARTBEAT_CODE][7:0];
        while (items_queued < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                if ($urandom_range(0, 3) != 0) push_req(ACT_TICK, 8'($urandom));
                push_req(ACT_BYTE, pick_code(CFG_RESPONSE_CODE));
                repeat ($urandom_range(0, 2)) push_req(ACT_BYTE, 8'($urandom));
                push_ticks(int'(link_regs[CFG_CONNECT_WAIT]), 6);
                push_req(ACT_BYTE, pick_code(CFG_CONFIRM_CODE));
                repeat ($urandom_range(0, 1)) push_req(ACT_BYTE, 8'($urandom));
                push_ticks(int'(link_regs[CFG_CONNECT_WAIT]), 6);
            end else if (kind < 80) begin
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_BYTES - 1)
                                                  : FRAME_BYTES;
                push_req(ACT_BYTE, hb);
                sum = hb;
                for (int i = 1; i < cut; i++) begin
                    if ($urandom_range(0, 15) == 0) push_req(ACT_TICK, 8'($urandom));
                    fb = 8'($urandom);
                    if (i == FRAME_BYTES - 1 && $urandom_range(0, 9) < 6) fb = SUM_OK - sum;
                    sum = sum + fb;
                    push_req(ACT_BYTE, fb);
                end
                if (cut < FRAME_BYTES) push_ticks(int'(link_regs[CFG_FRAME_TIMEOUT]) + 1, 25);
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 8)) push_req(1'($urandom), 8'($urandom));
            end else begin
                push_ticks(int'(link_regs[CFG_LINK_TIMEOUT]) + 1, 70);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        req_if.valid   = 1'b0;
        req_if.action  = ACT_TICK;
        req_if.rx_byte = '0;
        rsp_if.ready   = 1'b0;

        link_regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd10, 16'd1000, 16'd100};
        lnk_up    = 1'b0;
        lnk_phase = PH_IDLE;
        frm_cnt   = 0;
        frm_sum   = '0;
        cmd_lo    = '0;
        cmd_hi    = '0;
        frm_tmr   = '0;
        quiet_tmr = '0;
        win_tmr   = '0;
        win_byte  = '0;
        win_seen  = 1'b0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        next_regs[CFG_HEARTBEAT_CODE] = 16'h00FF;
        next_regs[CFG_INIT_CODE]      = 16'h0000;
        next_regs[CFG_RESPONSE_CODE]  = 16'h00FF;
        next_regs[CFG_CONFIRM_CODE]   = 16'h0000;
        next_regs[CFG_DEVICE_ID]      = 16'h00FF;
        next_regs[CFG_FRAME_TIMEOUT]  = 16'd2;
        next_regs[CFG_LINK_TIMEOUT]   = 16'd5;
        next_regs[CFG_CONNECT_WAIT]   = 16'd1;
        program_regs();

        // Byte opens the window, extra byte dropped, failed confirm, retry.
        push_req(ACT_BYTE, 8'hFF);
        push_req(ACT_BYTE, 8'h00);
        push_req(ACT_TICK, 8'h00);
        push_req(ACT_BYTE, 8'h55);
        push_req(ACT_TICK, 8'hFF);
        push_req(ACT_BYTE, 8'hFF);
        push_req(ACT_TICK, 8'h00);
        push_req(ACT_BYTE, 8'h00);
        push_req(ACT_TICK, 8'h00);
        // Drop a stray byte, then a full frame with good sum and command 0xFF00.
        push_req(ACT_BYTE, 8'h12);
        push_req(ACT_BYTE, 8'hFF);
        push_req(ACT_BYTE, 8'h00);
        push_req(ACT_BYTE, 8'hFF);
        push_req(ACT_BYTE, 8'h01);
        repeat (FRAME_BYTES - 4) push_req(ACT_BYTE, 8'h00);
        wait_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0) begin
                for (int i = 0; i < 8; i++) next_regs[i] = 16'hFFFF;
                next_regs[CFG_CONNECT_WAIT] = 16'd1;
            end else if (ph == 1) begin
                for (int i = 0; i < 8; i++) next_regs[i] = 16'h0000;
            end else begin
                for (int i = 0; i < 5; i++) next_regs[i] = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                    next_regs[CFG_RESPONSE_CODE] = next_regs[CFG_HEARTBEAT_CODE];
                next_regs[CFG_FRAME_TIMEOUT] = (ph == 3) ? 16'd1 : 16'($urandom_range(1, 20));
                next_regs[CFG_LINK_TIMEOUT]  = (ph == 3) ? 16'd1 : 16'($urandom_range(8, 60));
                next_regs[CFG_CONNECT_WAIT]  = (ph == 3) ? 16'd1 : 16'($urandom_range(1, 4));
            end
            program_regs();
            if (ph == N_PHASES - 1) quiet = 1'b1;
            gen_traffic(RANDOM_ITEMS / N_PHASES);
            if (ph == 2) stall_asks++;
            wait_idle();
        end

        $display("%0d requests over %0d register settings", items_taken, settings_used);
        $display("%0d link-ups, %0d frames answered, %0d commands", link_ups, replies, commands);
        if (mismatch_cnt == 0) begin
            $display("heartbeat_link_supervisor_top: match");
        end else begin
            $display("heartbeat_link_supervisor_top: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
rtl/hls_pkg.sv
rtl/hls_if.sv
rtl/heartbeat_link_supervisor_top.sv
dv/tb_top.sv
